// ===== sv/padded_string_crc32_defines.svh =====
// Assertion macros shared by the padded string CRC-32 block.
`ifndef PADDED_STRING_CRC32_DEFINES_SVH
`define PADDED_STRING_CRC32_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PSCRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pscrc same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PSCRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pscrc next-cycle check failed");

`endif

// ===== sv/pscrc_pkg.sv =====
// Package with types, constants and the word CRC function of the padded string CRC-32 block.
package pscrc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned PEND_W = 24;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_TOP  = 32'h8000_0000;

    // One input item as it travels through the block.
    typedef struct packed {
        logic [BYTE_W-1:0] char_byte;
        logic              has_byte;
        logic              last;
    } t_item;

    // A closed string waiting for its final combine.
    typedef struct packed {
        logic             valid;
        logic [CRC_W-1:0] body;
        logic [CRC_W-1:0] tail;
    } t_fin;

    typedef logic [CRC_W-1:0] t_cols [CRC_W];

    // Column i holds the CRC state after shifting a lone bit i through 32 steps.
    function automatic t_cols f_build_cols();
        t_cols            cols;
        logic [CRC_W-1:0] v;
        for (int i = 0; i < CRC_W; i++) begin
            v = CRC_W'(1) << i;
            for (int k = 0; k < CRC_W; k++) begin
                v = ((v & CRC_TOP) != '0) ? ((v << 1) ^ CRC_POLY) : (v << 1);
            end
            cols[i] = v;
        end
        return cols;
    endfunction

    localparam t_cols CRC_COLS = f_build_cols();

    // Feed one 32-bit word MSB first; the 32 shifts are linear, so this is an XOR network.
    function automatic logic [CRC_W-1:0] f_crc_word(logic [CRC_W-1:0] crc,
                                                    logic [CRC_W-1:0] word);
        logic [CRC_W-1:0] x;
        logic [CRC_W-1:0] r;
        x = crc ^ word;
        r = '0;
        for (int i = 0; i < CRC_W; i++) begin
            if (x[i]) begin
                r = r ^ CRC_COLS[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/pscrc_if.sv =====
// Valid/ready channel interfaces for the input bytes and the result checksum.
interface pscrc_in_if;
    import pscrc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_byte;
    logic              has_byte;
    logic              last;

    modport source (output valid, output char_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input char_byte, input has_byte, input last,
                    output ready);
endinterface

interface pscrc_out_if;
    import pscrc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CRC_W-1:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

// ===== sv/pscrc_accum.sv =====
// Byte accumulator: packs bytes into words, updates the body CRC and captures closed strings.
module pscrc_accum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  pscrc_pkg::t_item i_item,
    input  logic             i_fin_take,
    output pscrc_pkg::t_fin  o_fin
);
    import pscrc_pkg::*;

    logic [CRC_W-1:0]  r_body;
    logic [PEND_W-1:0] r_pend;
    logic [1:0]        r_pos;
    logic              r_fin_valid;
    logic [CRC_W-1:0]  r_fin_body;
    logic [CRC_W-1:0]  r_fin_tail;

    logic [CRC_W-1:0]  n_body;
    logic [PEND_W-1:0] n_pend;
    logic [1:0]        n_pos;
    logic [PEND_W-1:0] w_mask;

    // Byte packing and the body CRC update for a completed word.
    always_comb begin
        n_body = r_body;
        n_pend = r_pend;
        n_pos  = r_pos;
        if (i_item.has_byte) begin
            case (r_pos)
                2'd0: begin
                    n_pend[7:0] = i_item.char_byte;
                    n_pos       = 2'd1;
                end
                2'd1: begin
                    n_pend[15:8] = i_item.char_byte;
                    n_pos        = 2'd2;
                end
                2'd2: begin
                    n_pend[23:16] = i_item.char_byte;
                    n_pos         = 2'd3;
                end
                default: begin
                    n_body = f_crc_word(r_body, {i_item.char_byte, r_pend});
                    n_pos  = 2'd0;
                end
            endcase
        end
    end

    // Only the buffered bytes count toward the tail word; stale lanes are masked.
    always_comb begin
        case (n_pos)
            2'd0:    w_mask = 24'h00_0000;
            2'd1:    w_mask = 24'h00_00FF;
            2'd2:    w_mask = 24'h00_FFFF;
            default: w_mask = 24'hFF_FFFF;
        endcase
    end

    // State registers; a closing item hands off its words and restarts the string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body      <= CRC_INIT;
            r_pos       <= 2'd0;
            r_fin_valid <= 1'b0;
        end else begin
            if (i_go) begin
                if (i_item.last) begin
                    r_body <= CRC_INIT;
                    r_pos  <= 2'd0;
                end else begin
                    r_body <= n_body;
                    r_pos  <= n_pos;
                end
            end
            if (i_go && i_item.last) begin
                r_fin_valid <= 1'b1;
            end else if (i_fin_take) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_pend <= n_pend;
        end
        if (i_go && i_item.last) begin
            r_fin_body <= n_body;
            r_fin_tail <= {8'h00, n_pend & w_mask};
        end
    end

    assign o_fin = {r_fin_valid, r_fin_body, r_fin_tail};

endmodule

// ===== sv/pscrc_final.sv =====
// Final combine of body and tail CRCs, held in the result register.
module pscrc_final (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pscrc_pkg::t_fin i_fin,
    output logic            o_fin_take,
    pscrc_out_if.source     o_out
);
    import pscrc_pkg::*;

    logic             r_out_valid;
    logic [CRC_W-1:0] r_sum;
    logic [CRC_W-1:0] w_body_crc;
    logic [CRC_W-1:0] w_tail_crc;
    logic [CRC_W-1:0] n_sum;

    // Both word CRCs start fresh; the body CRC is then continued over the tail CRC.
    always_comb begin
        w_body_crc = f_crc_word(CRC_INIT, i_fin.body);
        w_tail_crc = f_crc_word(CRC_INIT, i_fin.tail);
        n_sum      = f_crc_word(w_body_crc, w_tail_crc);
    end

    // A closed string moves in when the result register is empty or being emptied.
    assign o_fin_take = i_fin.valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_fin_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_take) begin
            r_sum <= n_sum;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.checksum = r_sum;

endmodule

// ===== sv/padded_string_crc32.sv =====
// Top level of the padded string CRC-32 block: input register, accumulator and final combine.
// One byte item is taken per clock cycle while the input does not stall, also while a checksum
// waits to be transferred; the limit is the body CRC register, which a 32-bit XOR network
// updates once per cycle. A closing item (last = 1) passes through the input register, then
// the accumulator that packs bytes into little-endian words and takes the zero-padded tail,
// then the final combine that feeds the body and tail CRCs into a fresh CRC. The input stalls
// only when a closing item meets a closed string still waiting in the handoff slot.
// CRC: polynomial 0x04C11DB7, MSB first, no reflection, no final XOR.
`include "padded_string_crc32_defines.svh"

module padded_string_crc32 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pscrc_in_if.sink    i_in,
    pscrc_out_if.source o_out
);
    import pscrc_pkg::*;

    logic  r_in_valid;
    t_item r_in;
    logic  w_go;
    logic  w_fin_take;
    logic  w_fin_free;
    t_fin  w_fin;

    // A closing item may only leave the input register when the handoff slot is free.
    assign w_fin_free = !w_fin.valid || w_fin_take;
    assign w_go       = r_in_valid && (!r_in.last || w_fin_free);
    assign i_in.ready = !r_in_valid || w_go;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.char_byte <= i_in.char_byte;
            r_in.has_byte  <= i_in.has_byte;
            r_in.last      <= i_in.last;
        end
    end

    pscrc_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_item     (r_in),
        .i_fin_take (w_fin_take),
        .o_fin      (w_fin)
    );

    pscrc_final u_final (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fin      (w_fin),
        .o_fin_take (w_fin_take),
        .o_out      (o_out)
    );

    // The input stalls only behind a closing item.
    `PSCRC_ASSERT_NOW(a_stall_cause, !i_in.ready, r_in_valid && r_in.last)
    // A closing item leaving the input register is handed to the final combine.
    `PSCRC_ASSERT_NEXT(a_fin_capture, w_go && r_in.last, w_fin.valid)
    // A handed-off string shows up as a result in the next cycle.
    `PSCRC_ASSERT_NEXT(a_fin_to_out, w_fin_take, o_out.valid)

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the padded string CRC-32 block, driven over valid/ready channels.
`timescale 1ns / 1ps

module testbench;
    import pscrc_pkg::*;

    localparam int unsigned STRING_ITEMS = 1700;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned REPORT_MAX   = 10;

    logic i_clk;
    logic i_rst_n;

    pscrc_in_if  in_bus ();
    pscrc_out_if out_bus ();

    padded_string_crc32 DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    // Items waiting to be sent, and checksums waiting to come back.
    t_item            pending_items [$];
    logic [CRC_W-1:0] expected_checksums [$];

    // Shadow of the string state: CRC over complete words, buffered tail bytes and their count.
    logic [CRC_W-1:0]  str_body;
    logic [PEND_W-1:0] str_pending;
    logic [1:0]        str_fill;

    // Handshake bookkeeping shared between the sampling and driving edges.
    t_item       cur_item;
    bit          in_holding;
    bit          in_accepted;
    bit          in_calm;
    int unsigned in_gap;
    bit          out_taken;
    bit          out_calm;
    int unsigned out_stall;
    bit          progress;
    int unsigned idle_cycles;
    int unsigned error_count;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Feed one 32-bit word into a CRC, most significant bit first.
    function automatic logic [CRC_W-1:0] crc_feed_word(logic [CRC_W-1:0] crc,
                                                       logic [CRC_W-1:0] word);
        logic [CRC_W-1:0] acc;
        acc = crc ^ word;
        for (int k = 0; k < CRC_W; k++) begin
            if (acc[CRC_W-1]) begin
                acc = (acc << 1) ^ CRC_POLY;
            end else begin
                acc = acc << 1;
            end
        end
        return acc;
    endfunction

    // Wait before the next transfer: none in calm stretches, otherwise 0 to 13.
    function automatic int unsigned draw_wait(bit calm);
        if (calm) begin
            return 0;
        end
        if ($urandom_range(0, 2) == 0) begin
            return $urandom_range(0, 13);
        end
        return $urandom_range(0, 3);
    endfunction

    // Byte values lean toward the extremes now and then.
    function automatic logic [BYTE_W-1:0] draw_byte();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 8'h00;
        end
        if (pick == 1) begin
            return 8'hFF;
        end
        return BYTE_W'($urandom);
    endfunction

    task automatic clear_string_state();
        str_body    = CRC_INIT;
        str_pending = '0;
        str_fill    = 2'd0;
    endtask

    // Take one accepted item into the string state; a closing item yields a checksum.
    task automatic advance_string_crc(input t_item it);
        logic [CRC_W-1:0] keep;
        logic [CRC_W-1:0] tail_word;
        logic [CRC_W-1:0] tail_crc;
        if (it.has_byte) begin
            if (str_fill == 2'd3) begin
                str_body    = crc_feed_word(str_body, {it.char_byte, str_pending});
                str_pending = '0;
                str_fill    = 2'd0;
            end else begin
                if (str_fill == 2'd0) begin
                    str_pending = '0;
                end
                str_pending = str_pending | (PEND_W'(it.char_byte) << (8 * str_fill));
                str_fill    = str_fill + 2'd1;
            end
        end
        if (it.last) begin
            keep      = (32'h1 << (8 * str_fill)) - 32'h1;
            tail_word = {8'h00, str_pending} & keep;
            tail_crc  = crc_feed_word(CRC_INIT, tail_word);
            expected_checksums.push_back(
                crc_feed_word(crc_feed_word(CRC_INIT, str_body), tail_crc));
            clear_string_state();
        end
    endtask

    task automatic push_item(input logic [BYTE_W-1:0] b, input logic has, input logic fin);
        t_item it;
        it.char_byte = b;
        it.has_byte  = has;
        it.last      = fin;
        pending_items.push_back(it);
    endtask

    // Sample both channels at the rising edge; predict on input transfers, check on output.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (in_bus.valid && in_bus.ready) begin
                in_accepted = 1'b1;
                progress    = 1'b1;
                advance_string_crc(cur_item);
            end
            if (out_bus.valid && out_bus.ready) begin
                out_taken = 1'b1;
                progress  = 1'b1;
                if (expected_checksums.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("unexpected checksum %08h with nothing pending",
                                 out_bus.checksum);
                    end
                end else begin
                    logic [CRC_W-1:0] want;
                    want = expected_checksums.pop_front();
                    if (out_bus.checksum !== want) begin
                        error_count++;
                        if (error_count <= REPORT_MAX) begin
                            $display("checksum mismatch: expected %08h, got %08h",
                                     want, out_bus.checksum);
                        end
                    end
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
        end
    end

    // Input driver: present the next item after its drawn gap, hold it until transferred.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_accepted) begin
                in_accepted = 1'b0;
                in_holding  = 1'b0;
            end
            if (!in_holding) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() > 0) begin
                    cur_item   = pending_items.pop_front();
                    in_holding = 1'b1;
                    if ($urandom_range(0, 49) == 0) begin
                        in_calm = !in_calm;
                    end
                    in_gap = draw_wait(in_calm);
                    in_bus.char_byte <= cur_item.char_byte;
                    in_bus.has_byte  <= cur_item.has_byte;
                    in_bus.last      <= cur_item.last;
                end
            end
            in_bus.valid <= in_holding;
        end
    end

    // Output driver: after each transfer, hold ready low for a drawn number of cycles.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                out_taken = 1'b0;
                if ($urandom_range(0, 29) == 0) begin
                    out_calm = !out_calm;
                end
                out_stall = draw_wait(out_calm);
            end
            if (out_stall > 0) begin
                out_stall--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("testbench: done, errors");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned counted;
        int unsigned len;
        int unsigned shape;
        bit          close_on_byte;

        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.char_byte = '0;
        in_bus.has_byte  = 1'b0;
        in_bus.last      = 1'b0;
        out_bus.ready    = 1'b0;
        in_holding       = 1'b0;
        in_accepted      = 1'b0;
        in_calm          = 1'b0;
        in_gap           = 0;
        out_taken        = 1'b0;
        out_calm         = 1'b0;
        out_stall        = $urandom_range(0, 13);
        error_count      = 0;
        clear_string_state();

        // Empty string, and an empty item ahead of one.
        push_item(8'hA5, 1'b0, 1'b1);
        push_item(8'h3C, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        // Single bytes at the extremes, each carried on the closing item.
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        // Two bytes, closed on the second.
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h01, 1'b1, 1'b1);
        // Three bytes, closed by an item without a byte.
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hAA, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b1);
        // A full word leaves the tail empty.
        push_item(8'h12, 1'b1, 1'b0);
        push_item(8'h34, 1'b1, 1'b0);
        push_item(8'h56, 1'b1, 1'b0);
        push_item(8'h78, 1'b1, 1'b1);
        // One word plus a one-byte tail, all ones.
        for (int i = 0; i < 4; i++) begin
            push_item(8'hFF, 1'b1, 1'b0);
        end
        push_item(8'hFF, 1'b1, 1'b1);
        // A byte, an ignored item, then the close.
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'hC3, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);

        // Random strings of mostly short length, with ignored items mixed in.
        counted = 0;
        while (counted < STRING_ITEMS) begin
            shape = $urandom_range(0, 9);
            if (shape < 6) begin
                len = $urandom_range(0, 8);
            end else if (shape < 9) begin
                len = $urandom_range(0, 16);
            end else begin
                len = $urandom_range(17, 40);
            end
            close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_item(draw_byte(), 1'b0, 1'b0);
                end
                push_item(draw_byte(), 1'b1, close_on_byte && (i == len - 1));
                counted++;
            end
            if (!close_on_byte) begin
                push_item(draw_byte(), 1'b0, 1'b1);
                counted++;
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every item sent, every checksum back, then a quiet wait for stray checksums.
        while (pending_items.size() > 0 || in_holding) begin
            @(posedge i_clk);
        end
        while (expected_checksums.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_checksums.size() > 0) begin
            error_count++;
        end

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pscrc_pkg.sv
sv/pscrc_if.sv
sv/pscrc_accum.sv
sv/pscrc_final.sv
sv/padded_string_crc32.sv
test/testbench.sv
